/* rtl/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared constants, types and channel arithmetic for the RGBA 2x downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WCFG_W     = 13;
    localparam int HCFG_W     = 16;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 32;
    localparam int SUM_W      = 9;
    localparam int PAIR_W     = 4 * SUM_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Line store access issued together with an accepted item.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [LINE_AW-1:0] addr;
        logic [PAIR_W-1:0]  wr_data;
    } line_req_t;

    // Item held between the pair-sum stage and the averaging stage.
    typedef struct packed {
        logic              valid;
        logic              use_line;
        logic              last;
        logic [PAIR_W-1:0] pair;
    } avg_item_t;

    // Per-channel horizontal sum of two RGBA8 pixels, four 9-bit fields.
    function automatic logic [PAIR_W-1:0] pair_add(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PAIR_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < 4; ch++) begin
            r[SUM_W*ch +: SUM_W] = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
        end
        return r;
    endfunction

    // Rounded average of two pair sums: (top + bottom + 2) / 4 per channel.
    function automatic logic [PIX_W-1:0] box_average(input logic [PAIR_W-1:0] top,
                                                     input logic [PAIR_W-1:0] bottom);
        logic [PIX_W-1:0] r;
        logic [SUM_W:0]   s;
        r = '0;
        for (int ch = 0; ch < 4; ch++) begin
            s = {1'b0, top[SUM_W*ch +: SUM_W]} + {1'b0, bottom[SUM_W*ch +: SUM_W]}
                + 10'd2;
            r[8*ch +: 8] = s[9:2];
        end
        return r;
    endfunction

endpackage

/* rtl/rbd_line_ram.sv */
// ----------------------------------------------------------------------------
// rbd_line_ram
// Line store of even-row pair sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbd_line_ram (
    input  logic                      aclk,
    input  rbd_pkg::line_req_t        req,
    output logic [rbd_pkg::PAIR_W-1:0] rd_data
);

    logic [rbd_pkg::PAIR_W-1:0] mem [rbd_pkg::LINE_DEPTH];
    logic [rbd_pkg::PAIR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
    end

    // Read data holds while no new read is issued, which covers output stalls.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rbd_ctrl
// Geometry registers, raster counters, pair sums and line store access.
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rbd_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           avg_adv,
    output rbd_pkg::line_req_t             line_req,
    output rbd_pkg::avg_item_t             avg_item
);

    logic [rbd_pkg::WCFG_W-1:0] width_reg, width_next;
    logic [rbd_pkg::HCFG_W-1:0] height_reg, height_next;
    logic [rbd_pkg::COL_W-1:0]  col_reg, col_next;
    logic [rbd_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [rbd_pkg::PIX_W-1:0]  held_reg, held_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_use_line_reg, s1_last_reg;
    logic [rbd_pkg::PAIR_W-1:0] s1_pair_reg;

    logic [rbd_pkg::WCFG_W-1:0] weff;
    logic [rbd_pkg::HCFG_W-1:0] heff;
    logic [rbd_pkg::COL_W-1:0]  c;
    logic [rbd_pkg::ROW_W-1:0]  r;
    logic                       single_col, single_row, have_pair, emit, last, accept;
    logic                       wrap_col, wrap_row;
    logic [rbd_pkg::LINE_AW-1:0] x;
    logic [rbd_pkg::COL_W-1:0]  ow;
    logic [rbd_pkg::ROW_W-1:0]  oh, y;
    logic [rbd_pkg::PAIR_W-1:0] pair;
    logic [rbd_pkg::WCFG_W-1:0] c_inc;
    logic [rbd_pkg::ROW_W:0]    r_inc;

    assign accept  = s_valid && s_ready;
    assign s_ready = !s1_valid_reg || avg_adv;

    always_comb begin
        // A zero size acts as one; the width saturates at the line capacity.
        weff = width_reg;
        if (width_reg == '0) begin
            weff = rbd_pkg::WCFG_W'(1);
        end else if (width_reg > rbd_pkg::WCFG_W'(rbd_pkg::MAX_WIDTH)) begin
            weff = rbd_pkg::WCFG_W'(rbd_pkg::MAX_WIDTH);
        end
        heff = (height_reg == '0) ? rbd_pkg::HCFG_W'(1) : height_reg;

        c = ({1'b0, col_reg} >= weff) ? '0 : col_reg;
        r = (row_reg >= heff) ? '0 : row_reg;

        single_col = (weff == rbd_pkg::WCFG_W'(1));
        single_row = (heff == rbd_pkg::HCFG_W'(1));
        have_pair  = single_col || c[0];
        pair       = rbd_pkg::pair_add(single_col ? s_pixel : held_reg, s_pixel);
        x          = c[rbd_pkg::COL_W-1:1];
        emit       = have_pair && (single_row || r[0]);

        ow = single_col ? rbd_pkg::COL_W'(1) : weff[rbd_pkg::WCFG_W-1:1];
        oh = single_row ? rbd_pkg::ROW_W'(1) : {1'b0, heff[rbd_pkg::HCFG_W-1:1]};
        y  = single_row ? '0 : {1'b0, r[rbd_pkg::ROW_W-1:1]};
        last = (({1'b0, x} + rbd_pkg::COL_W'(1)) == ow) && ((y + rbd_pkg::ROW_W'(1)) == oh);

        c_inc    = {1'b0, c} + rbd_pkg::WCFG_W'(1);
        r_inc    = {1'b0, r} + (rbd_pkg::ROW_W+1)'(1);
        wrap_col = (c_inc >= weff);
        wrap_row = (r_inc >= {1'b0, heff});
    end

    always_comb begin
        line_req.wr_en   = accept && have_pair && !single_row && !r[0];
        line_req.rd_en   = accept && have_pair && !single_row && r[0];
        line_req.addr    = x;
        line_req.wr_data = pair;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rbd_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata[rbd_pkg::WCFG_W-1:0];
                rbd_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata[rbd_pkg::HCFG_W-1:0];
                default: ;
            endcase
        end

        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept) begin
            if (wrap_col) begin
                col_next = '0;
                row_next = wrap_row ? '0 : r_inc[rbd_pkg::ROW_W-1:0];
            end else begin
                col_next = c_inc[rbd_pkg::COL_W-1:0];
                row_next = r;
            end
            if (!have_pair) begin
                held_next = s_pixel;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (s_ready) begin
            s1_valid_next = accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= rbd_pkg::WCFG_W'(1);
            height_reg   <= rbd_pkg::HCFG_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            held_reg     <= held_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pair_reg     <= pair;
            s1_use_line_reg <= !single_row;
            s1_last_reg     <= last;
        end
    end

    always_comb begin
        avg_item.valid    = s1_valid_reg;
        avg_item.use_line = s1_use_line_reg;
        avg_item.last     = s1_last_reg;
        avg_item.pair     = s1_pair_reg;
    end

endmodule

/* rtl/rbd_avg.sv */
// ----------------------------------------------------------------------------
// rbd_avg
// Combines the stored top pair sum with the current one and holds the result.
// ----------------------------------------------------------------------------
module rbd_avg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbd_pkg::avg_item_t          avg_item,
    input  logic [rbd_pkg::PAIR_W-1:0]  line_data,
    output logic                        avg_adv,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbd_pkg::PIX_W-1:0]   m_out_pixel,
    output logic                        m_last_of_level
);

    logic                       m_valid_reg, m_valid_next;
    logic [rbd_pkg::PIX_W-1:0]  pixel_reg;
    logic                       last_reg;
    logic [rbd_pkg::PAIR_W-1:0] top;
    logic [rbd_pkg::PIX_W-1:0]  result;

    assign avg_adv = !m_valid_reg || m_ready;

    // A single-row source pairs each pair sum with itself.
    assign top    = avg_item.use_line ? line_data : avg_item.pair;
    assign result = rbd_pkg::box_average(top, avg_item.pair);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (avg_adv) begin
            m_valid_next = avg_item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (avg_adv && avg_item.valid) begin
            pixel_reg <= result;
            last_reg  <= avg_item.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_pixel     = pixel_reg;
    assign m_last_of_level = last_reg;

endmodule

/* rtl/rgba_box_downsample_2x_top.sv */
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x_top
// 2x2 box-filter downsampler for RGBA8 images in raster order.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     s_valid/s_ready    s_pixel[31:0]
//  result    m_valid/m_ready    m_out_pixel[31:0], m_last_of_level
//  config    cfg_wr_en          cfg_index[0], cfg_wdata[15:0]
//
// One item is accepted per cycle unless the result side stalls. The item of an odd
// row's odd column (any row or column of a one-row or one-column level) is registered
// beside the line store read, and the result it completes then in the output register.
// Reset sets both dimensions to 1 and clears the counters; the line store needs
// no clearing, as each odd row reads what its even row wrote while the geometry holds.
// A stalled result holds one item in the output register and one in the
// averaging stage before the input side stops.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rbd_pkg::PIX_W-1:0]      s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rbd_pkg::PIX_W-1:0]      m_out_pixel,
    output logic                           m_last_of_level
);

    rbd_pkg::line_req_t         line_req;
    rbd_pkg::avg_item_t         avg_item;
    logic [rbd_pkg::PAIR_W-1:0] line_data;
    logic                       avg_adv;

    rbd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .avg_adv   (avg_adv),
        .line_req  (line_req),
        .avg_item  (avg_item)
    );

    rbd_line_ram u_line_ram (
        .aclk    (aclk),
        .req     (line_req),
        .rd_data (line_data)
    );

    rbd_avg u_avg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .avg_item        (avg_item),
        .line_data       (line_data),
        .avg_adv         (avg_adv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_pixel     (m_out_pixel),
        .m_last_of_level (m_last_of_level)
    );

endmodule

/* dv/tb_rgba_box_downsample_2x_top.sv */
// ----------------------------------------------------------------------------
// tb_rgba_box_downsample_2x_top
// Self-checking bench for the 2x2 box-filter mip downsampler. Each accepted
// source pixel is run through a behavioral copy of the filter, and each result
// item is compared against the oldest predicted mip pixel and level-end flag.
// Directed levels cover the edge geometries and rounding. Random levels, some
// cut short by a geometry change, run under three idle mixes and one long
// result stall.
// ----------------------------------------------------------------------------
module tb_rgba_box_downsample_2x_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned MAX_PRINTS    = 100;
    localparam int unsigned WIDE_ITEMS    = 128;
    localparam int unsigned TALL_ITEMS    = 96;

    typedef struct packed {
        logic [rbd_pkg::PIX_W-1:0] px;
        logic                      last;
    } mip_px_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index = rbd_pkg::REG_IMAGE_WIDTH;
    logic [rbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [rbd_pkg::PIX_W-1:0]      s_pixel   = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [rbd_pkg::PIX_W-1:0]      m_out_pixel;
    logic                           m_last_of_level;

    // Behavioral copy of the filter state and the geometry registers.
    logic [rbd_pkg::PAIR_W-1:0] line_sums [0:rbd_pkg::LINE_DEPTH-1] = '{default: '0};
    logic [rbd_pkg::PIX_W-1:0]  left_px   = '0;
    int unsigned                col_q     = 0;
    int unsigned                row_q     = 0;
    logic [rbd_pkg::WCFG_W-1:0] cfg_width  = rbd_pkg::WCFG_W'(1);
    logic [rbd_pkg::HCFG_W-1:0] cfg_height = rbd_pkg::HCFG_W'(1);

    mip_px_t     mip_expected [$];
    mip_px_t     mip_want;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    logic        hold_request = 1'b0;

    rgba_box_downsample_2x_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_pixel     (m_out_pixel),
        .m_last_of_level (m_last_of_level)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------
    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > rbd_pkg::MAX_WIDTH) return rbd_pkg::MAX_WIDTH;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return 32'(cfg_height);
    endfunction

    function automatic logic [rbd_pkg::PAIR_W-1:0] chan_pair_sums(
            input logic [rbd_pkg::PIX_W-1:0] a, input logic [rbd_pkg::PIX_W-1:0] b);
        logic [rbd_pkg::PAIR_W-1:0] sums;
        for (int ch = 0; ch < 4; ch++) begin
            sums[9*ch +: 9] = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
        end
        return sums;
    endfunction

    function automatic logic [rbd_pkg::PIX_W-1:0] quad_mean(
            input logic [rbd_pkg::PAIR_W-1:0] upper, input logic [rbd_pkg::PAIR_W-1:0] lower);
        logic [rbd_pkg::PIX_W-1:0] mean;
        logic [10:0]               total;
        for (int ch = 0; ch < 4; ch++) begin
            total = {2'b00, upper[9*ch +: 9]} + {2'b00, lower[9*ch +: 9]} + 11'd2;
            mean[8*ch +: 8] = total[9:2];
        end
        return mean;
    endfunction

    function automatic void filter_pixel(input logic [rbd_pkg::PIX_W-1:0] px);
        int unsigned                w_eff, h_eff, c, r, x, y, out_w, out_h;
        logic [rbd_pkg::PAIR_W-1:0] pair;
        logic                       has_pair;
        mip_px_t                    res;
        w_eff = eff_width();
        h_eff = eff_height();
        if (col_q >= w_eff) col_q = 0;
        if (row_q >= h_eff) row_q = 0;
        c = col_q;
        r = row_q;
        has_pair = 1'b1;
        pair = '0;
        if (w_eff == 1) begin
            pair = chan_pair_sums(px, px);
        end else if (c % 2 == 1) begin
            pair = chan_pair_sums(left_px, px);
        end else begin
            left_px = px;
            has_pair = 1'b0;
        end
        if (has_pair) begin
            x = c / 2;
            y = r / 2;
            out_w = (w_eff > 1) ? w_eff / 2 : 1;
            out_h = (h_eff > 1) ? h_eff / 2 : 1;
            if (h_eff == 1 || r % 2 == 1) begin
                // A single-row level averages the pair with itself.
                res.px = (h_eff == 1) ? quad_mean(pair, pair) : quad_mean(line_sums[x], pair);
                res.last = (x + 1 == out_w) && ((h_eff == 1) || (y + 1 == out_h));
                mip_expected = {mip_expected, res};
            end else begin
                line_sums[x] = pair;
            end
        end
        if (c + 1 >= w_eff) begin
            col_q = 0;
            row_q = (r + 1 >= h_eff) ? 0 : r + 1;
        end else begin
            col_q = c + 1;
        end
    endfunction

    function automatic bit at_level_start();
        return (col_q == 0 || col_q >= eff_width()) && (row_q == 0 || row_q >= eff_height());
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mip_expected.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", m_out_pixel));
            end else begin
                mip_want = mip_expected.pop_front();
                if (m_out_pixel !== mip_want.px)
                    report_mismatch($sformatf("out_pixel %h, want %h", m_out_pixel, mip_want.px));
                if (m_last_of_level !== mip_want.last)
                    report_mismatch($sformatf("last_of_level %b, want %b", m_last_of_level,
                                              mip_want.last));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side readiness, with a single long hold-off once requested.
    initial begin : result_sink
        int unsigned hold_left;
        logic        hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [rbd_pkg::PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_pixel(px);
    endtask

    function automatic logic [rbd_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Even-row items give no result, so a settle wait of SETTLE_CYCLES lets them land.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mip_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [rbd_pkg::CFG_DATA_W-1:0] w_word,
                                input logic [rbd_pkg::CFG_DATA_W-1:0] h_word);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_index <= rbd_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w_word;
        @(posedge aclk);
        cfg_width = w_word[rbd_pkg::WCFG_W-1:0];
        cfg_index <= rbd_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h_word;
        @(posedge aclk);
        cfg_height = h_word;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_level_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
    endtask

    function automatic logic [rbd_pkg::CFG_DATA_W-1:0] random_width_word();
        int unsigned pick, w;
        logic [2:0]  junk;
        pick = $urandom_range(0, 19);
        junk = 3'($urandom);
        if (pick == 0) w = 0;
        else if (pick == 1) w = $urandom_range(11, 64);
        else w = $urandom_range(1, 10);
        // The bits above the 13-bit width field must be ignored.
        return {junk, w[12:0]};
    endfunction

    function automatic logic [rbd_pkg::CFG_DATA_W-1:0] random_height_word();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return rbd_pkg::CFG_DATA_W'($urandom_range(9, 24));
        return rbd_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_geometry();
        // A 1x1 level returns every pixel unchanged and flags it as last.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h807F_01FE);
    endtask

    task automatic test_widest_line();
        // An oversized width clamps to the maximum. The start of the even row
        // fills the low end of the line store, which covers every entry that a
        // later level cut short by a geometry change can read.
        set_geometry(16'hFFFF, 16'd2);
        send_level_random(WIDE_ITEMS);
    endtask

    task automatic test_rounding();
        set_geometry(16'd4, 16'd2);
        send_pixel(32'hFF01_0101);
        send_pixel(32'hFF00_0101);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFFFF_0000);
        send_pixel(32'hFF00_0001);
        send_pixel(32'hFF00_0000);
        send_pixel(32'h00FF_FF00);
        send_pixel(32'h0000_0080);
    endtask

    task automatic test_odd_edges();
        // Odd sizes drop the last column and row.
        set_geometry(16'd3, 16'd3);
        send_level_random(9);
        // A single column pairs each pixel with itself.
        set_geometry(16'd1, 16'd3);
        send_level_random(3);
        // A single row emits each pair at once.
        set_geometry(16'd5, 16'd1);
        send_level_random(5);
        // Zero sizes act as one.
        set_geometry(16'd0, 16'd0);
        send_level_random(2);
    endtask

    task automatic test_random_levels(input int unsigned n_items);
        int unsigned sent, total, cut;
        sent = 0;
        while (sent < n_items) begin
            set_geometry(random_width_word(), random_height_word());
            total = eff_width() * eff_height();
            cut = total;
            if (total > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, total - 1);
            send_level_random(cut);
            sent += cut;
            if (cut < total) begin
                // Geometry change in the middle of a level, then run to its end.
                set_geometry(random_width_word(), random_height_word());
                while (!at_level_start()) begin
                    send_pixel(random_pixel());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_result_backpressure();
        set_geometry(16'd8, 16'd4);
        hold_request = 1'b1;
        send_level_random(3 * eff_width() * eff_height());
    endtask

    task automatic test_tallest_column();
        // The top of a full-height single column; the run ends inside the level.
        set_geometry(16'd1, 16'hFFFF);
        send_level_random(TALL_ITEMS);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 13;
        recv_gap_pct = 66;
        test_default_geometry();
        test_widest_line();
        test_rounding();
        test_odd_edges();
        test_random_levels(380);
        test_result_backpressure();

        send_gap_pct = 66;
        recv_gap_pct = 13;
        test_random_levels(380);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_levels(330);
        test_tallest_column();

        wait_quiet();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
